// ===== src/mmd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmd_pkg: shared types and constants for the min-max distance block
// Field widths, fixed-point constants and the control/status structs that
// pass between the accumulator, the divider and the top level.
// ----------------------------------------------------------------------------
package mmd_pkg;

   // Field widths
   localparam int VALUE_W = 16;            // signed Q8.8 element
   localparam int MAG_W   = VALUE_W + 1;   // magnitude up to 32768
   localparam int SUM_W   = 32;            // Q24.8 magnitude sums
   localparam int DIST_W  = 17;            // unsigned Q1.16, up to 1.0

   // Fixed-point constants
   localparam int FRAC_W = 16;                       // quotient fraction bits
   localparam logic [DIST_W-1:0] ONE_Q16 = DIST_W'(1) << FRAC_W;
   localparam logic [SUM_W-1:0] SUM_FULL_SCALE = '1;

   // Divider sequencing: one quotient bit per cycle
   localparam int DIV_STEPS = FRAC_W + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   // Accumulator control
   typedef struct packed {
      logic add;     // fold the current pair into the sums
      logic clear;   // zero both sums
   } mmd_acc_ctrl_type;

   // Divider status
   typedef struct packed {
      logic              busy;
      logic              done;       // one-cycle pulse, quotient valid
      logic              den_zero;   // divisor was zero
      logic [DIST_W-1:0] quotient;   // floor(num * 2^16 / den)
   } mmd_div_status_type;

endpackage

// ===== src/mmd_accum.sv =====
// ----------------------------------------------------------------------------
// mmd_accum: numerator / denominator accumulator
// Folds one signed element pair per cycle into two saturating magnitude sums.
// Same-sign pairs add min to the numerator and max to the denominator; any
// other pair adds both magnitudes to the denominator.
// ----------------------------------------------------------------------------
module mmd_accum
   import mmd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  mmd_acc_ctrl_type          ctrl,
   input  logic signed [VALUE_W-1:0] first_value,
   input  logic signed [VALUE_W-1:0] second_value,
   output logic [SUM_W-1:0]          numerator_sum,
   output logic [SUM_W-1:0]          denominator_sum
);

   logic [SUM_W-1:0] num_ff, num_in;
   logic [SUM_W-1:0] den_ff, den_in;

   logic [MAG_W-1:0] mag_a, mag_b, mag_lo, mag_hi;
   logic             a_pos, a_neg, b_pos, b_neg, same_sign;
   logic [MAG_W:0]   den_add;
   logic [MAG_W-1:0] num_add;
   logic [SUM_W:0]   num_sum, den_sum;

   // Magnitudes and sign classes
   always_comb begin
      mag_a = first_value[VALUE_W-1]
            ? MAG_W'(-{first_value[VALUE_W-1], first_value})
            : MAG_W'({1'b0, first_value});
      mag_b = second_value[VALUE_W-1]
            ? MAG_W'(-{second_value[VALUE_W-1], second_value})
            : MAG_W'({1'b0, second_value});
      a_neg = first_value[VALUE_W-1];
      b_neg = second_value[VALUE_W-1];
      a_pos = !a_neg && (first_value != '0);
      b_pos = !b_neg && (second_value != '0);
      same_sign = (a_pos && b_pos) || (a_neg && b_neg);
      mag_lo = (mag_a < mag_b) ? mag_a : mag_b;
      mag_hi = (mag_a < mag_b) ? mag_b : mag_a;
   end

   // Saturating adds; two saturating adds in a row equal one of their sum
   always_comb begin
      num_add = same_sign ? mag_lo : '0;
      den_add = same_sign ? {1'b0, mag_hi} : ({1'b0, mag_a} + {1'b0, mag_b});
      num_sum = {1'b0, num_ff} + (SUM_W + 1)'(num_add);
      den_sum = {1'b0, den_ff} + (SUM_W + 1)'(den_add);

      num_in = num_ff;
      den_in = den_ff;
      if (ctrl.clear) begin
         num_in = '0;
         den_in = '0;
      end else if (ctrl.add) begin
         num_in = num_sum[SUM_W] ? SUM_FULL_SCALE : num_sum[SUM_W-1:0];
         den_in = den_sum[SUM_W] ? SUM_FULL_SCALE : den_sum[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
         den_ff <= '0;
      end else begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign numerator_sum   = num_ff;
   assign denominator_sum = den_ff;

`ifndef SYNTHESIS
   // Each pair adds no more to the numerator than to the denominator
   a_num_le_den: assert property (@(posedge clock) disable iff (reset)
      num_ff <= den_ff)
      else $error("numerator sum exceeds denominator sum");

   // A clear empties both sums on the next cycle
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (num_ff == '0) && (den_ff == '0))
      else $error("sums not cleared");
`endif

endmodule

// ===== src/mmd_divider.sv =====
// ----------------------------------------------------------------------------
// mmd_divider: restoring divider, one quotient bit per cycle
// Forms floor(num * 2^16 / den) for num <= den with one shared 33-bit
// subtract-compare.
// ----------------------------------------------------------------------------
module mmd_divider
   import mmd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   numerator,
   input  logic [SUM_W-1:0]   denominator,
   output mmd_div_status_type status
);

   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [FRAC_W:0]   bits_ff, bits_in;     // dividend bits still to shift in
   logic [DIST_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              zero_ff, zero_in;

   logic [SUM_W:0]    shifted, diff;
   logic              fits;

   // Shared subtract-compare
   always_comb begin
      shifted = {rem_ff, bits_ff[FRAC_W]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
   end

   // Step sequencing
   always_comb begin
      rem_in   = rem_ff;
      den_in   = den_ff;
      bits_in  = bits_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      if (start) begin
         // top dividend bits num[31:1] are below den, so their quotient is zero
         rem_in   = numerator >> 1;
         bits_in  = {numerator[0], {FRAC_W{1'b0}}};
         den_in   = denominator;
         quot_in  = '0;
         count_in = CNT_W'(DIV_STEPS);
         busy_in  = 1'b1;
         zero_in  = (denominator == '0);
      end else if (busy_ff) begin
         rem_in   = fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
         bits_in  = {bits_ff[FRAC_W-1:0], 1'b0};
         quot_in  = {quot_ff[DIST_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
      zero_ff <= zero_in;
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.den_zero = zero_ff;
   assign status.quotient = quot_ff;

`ifndef SYNTHESIS
   // Quotient never exceeds 1.0 for a nonzero divisor
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !zero_ff) |-> (quot_ff <= ONE_Q16))
      else $error("quotient above 1.0");

   // Done follows the last busy step
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a finishing step");
`endif

endmodule

// ===== src/minmax_distance.sv =====
// Sequence: a pair without last_pair is only folded into the sums; the last
// pair gives its result through the load (ST_START), 17 divider steps, the
// done pulse and the output load (ST_OUT), plus any wait on rsp_ready.
// Throughput: one pair per cycle inside a vector; the 17-step bit-serial
// divider holds off req_ready until the result is loaded, plus any rsp wait.
// Reset: synchronous, active high; clears sums and sets the threshold to 1.0.
// ----------------------------------------------------------------------------
// minmax_distance: signed min-max (weighted Jaccard) distance
// Accumulates element pairs, then divides once per vector and flags whether
// the distance is within the programmed threshold.
// ----------------------------------------------------------------------------
module minmax_distance
   import mmd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration write
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [DIST_W-1:0]         csr_distance_threshold,
   // element pairs
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_first_value,
   input  logic signed [VALUE_W-1:0] req_second_value,
   input  logic                      req_last_pair,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic                      rsp_within_threshold
);

   typedef enum logic [1:0] {
      ST_ACCUM,   // taking pairs
      ST_START,   // launch divider, clear sums
      ST_DIV,     // divider running
      ST_OUT      // load the result register
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               within_ff, within_in;
   logic [DIST_W-1:0]  thresh_ff;

   mmd_acc_ctrl_type   acc_ctrl;
   mmd_div_status_type div_status;
   logic [SUM_W-1:0]   numerator_sum, denominator_sum;
   logic               req_xfer, div_start;
   logic [DIST_W-1:0]  quot_clamped, dist_calc;

   assign req_ready = (state_ff == ST_ACCUM);
   assign req_xfer  = req_valid && req_ready;
   assign div_start = (state_ff == ST_START);

   assign acc_ctrl.add   = req_xfer;
   assign acc_ctrl.clear = div_start;

   mmd_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (acc_ctrl),
      .first_value     (req_first_value),
      .second_value    (req_second_value),
      .numerator_sum   (numerator_sum),
      .denominator_sum (denominator_sum)
   );

   mmd_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (numerator_sum),
      .denominator (denominator_sum),
      .status      (div_status)
   );

   // Threshold register; writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ONE_Q16;
      end else if (csr_valid) begin
         thresh_ff <= csr_distance_threshold;
      end
   end

   // Distance from the held quotient
   always_comb begin
      quot_clamped = (div_status.quotient > ONE_Q16) ? ONE_Q16 : div_status.quotient;
      dist_calc    = div_status.den_zero ? ONE_Q16 : (ONE_Q16 - quot_clamped);
   end

   // Sequencer and result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      dist_in      = dist_ff;
      within_in    = within_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_xfer && req_last_pair) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               dist_in      = dist_calc;
               within_in    = (dist_calc <= thresh_ff);
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dist_ff   <= dist_in;
      within_ff <= within_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_distance         = dist_ff;
   assign rsp_within_threshold = within_ff;

`ifndef SYNTHESIS
   // A new result is loaded only from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result loaded outside output state");

   // Divider is idle whenever pairs are taken
   a_idle_accum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) |-> !div_status.busy)
      else $error("divider busy while accumulating");
`endif

endmodule
